// ===== hdl/itrf_pkg.sv =====
// shared types and command codes for the i2c target register file
package itrf_pkg;

	localparam int unsigned ByteW = 8;
	localparam int unsigned CmdW  = 3;

	localparam logic [CmdW-1:0] CMD_ADDR  = 3'd0;
	localparam logic [CmdW-1:0] CMD_NACK  = 3'd1;
	localparam logic [CmdW-1:0] CMD_TXE   = 3'd2;
	localparam logic [CmdW-1:0] CMD_RX    = 3'd3;
	localparam logic [CmdW-1:0] CMD_HRD   = 3'd4;
	localparam logic [CmdW-1:0] CMD_HWR   = 3'd5;

	typedef struct packed {
		logic             tx_valid;
		logic [ByteW-1:0] tx_byte;
		logic             nack_update;
		logic             nack_level;
		logic [ByteW-1:0] host_read_data;
	} res_t;

endpackage

// ===== hdl/itrf_req_if.sv =====
// request channel: bus events and host accesses
interface itrf_req_if;
	logic       valid;
	logic       ready;
	logic [2:0] cmd;
	logic [7:0] data_byte;
	logic [7:0] host_addr;

	modport source (output valid, output cmd, output data_byte, output host_addr, input ready);
	modport sink (input valid, input cmd, input data_byte, input host_addr, output ready);
endinterface

// ===== hdl/itrf_rsp_if.sv =====
// response channel: transmit byte, nack control and host read data
interface itrf_rsp_if;
	logic       valid;
	logic       ready;
	logic       tx_valid;
	logic [7:0] tx_byte;
	logic       nack_update;
	logic       nack_level;
	logic [7:0] host_read_data;

	modport source (output valid, output tx_valid, output tx_byte, output nack_update,
		output nack_level, output host_read_data, input ready);
	modport sink (input valid, input tx_valid, input tx_byte, input nack_update,
		input nack_level, input host_read_data, output ready);
endinterface

// ===== hdl/itrf_ram.sv =====
// generic single-port-write, single-port-read ram with registered read data
module itrf_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ===== hdl/itrf_core.sv =====
// sequencer: pointer state, entry valid bits and read-modify-write of the register ram
module itrf_core #(
	parameter int unsigned MEM_DEPTH = 256
) (
	input  logic         clk,
	input  logic         arst_n,
	itrf_req_if.sink     req,
	input  logic [7:0]   mem_size,
	output logic         res_valid,
	input  logic         res_ready,
	output itrf_pkg::res_t res
);
	localparam int unsigned AW = $clog2(MEM_DEPTH);

	typedef enum logic {S_IDLE, S_EXEC} state_t;

	state_t      st_q;
	logic [7:0]  ptr_q;
	logic [7:0]  idx_q;
	logic [MEM_DEPTH-1:0] vld_q;

	logic [2:0]  cmd_s1;
	logic [7:0]  data_s1;
	logic [7:0]  addr_s1;
	logic        inr_s1;
	logic        vld_s1;

	logic        acc;
	logic        fire;
	logic [7:0]  rd_addr;
	logic        rd_inr;
	logic [8:0]  lim;
	logic [7:0]  rdata;
	logic [7:0]  rd_byte;
	logic [7:0]  ptr_inc;
	logic [7:0]  ptr_n;
	logic [7:0]  idx_n;
	logic        ram_we;

	assign req.ready = (st_q == S_IDLE);
	assign acc       = req.valid && req.ready;
	assign fire      = (st_q == S_EXEC) && res_ready;
	assign res_valid = (st_q == S_EXEC);

	// effective limit is the smaller of mem_size and the memory depth
	assign lim     = ({1'b0, mem_size} < 9'(MEM_DEPTH)) ? {1'b0, mem_size} : 9'(MEM_DEPTH);
	assign rd_addr = (req.cmd == itrf_pkg::CMD_HRD || req.cmd == itrf_pkg::CMD_HWR)
		? req.host_addr : ptr_q;
	assign rd_inr  = ({1'b0, rd_addr} < lim);

	itrf_ram #(
		.WIDTH (8),
		.DEPTH (MEM_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (addr_s1[AW-1:0]),
		.wdata (data_s1),
		.re    (acc),
		.raddr (rd_addr[AW-1:0]),
		.rdata (rdata)
	);

	// entries never written read as zero
	assign rd_byte = (inr_s1 && vld_s1) ? rdata : 8'h00;
	assign ptr_inc = ptr_q + 8'd1;

	always_comb begin
		res    = '0;
		ptr_n  = ptr_q;
		idx_n  = idx_q;
		ram_we = 1'b0;
		case (cmd_s1)
			itrf_pkg::CMD_ADDR: begin
				idx_n           = 8'd0;
				res.nack_update = 1'b1;
				if (data_s1 != 8'd0) begin
					res.tx_valid = 1'b1;
					res.tx_byte  = rd_byte;
					ptr_n        = ptr_inc;
				end else begin
					ptr_n = 8'd0;
				end
			end
			itrf_pkg::CMD_TXE: begin
				res.tx_valid = 1'b1;
				res.tx_byte  = rd_byte;
				ptr_n        = ptr_inc;
			end
			itrf_pkg::CMD_RX: begin
				if (idx_q == 8'd0) begin
					ptr_n = data_s1;
					idx_n = idx_q + 8'd1;
				end else if (inr_s1) begin
					ram_we          = fire;
					ptr_n           = ptr_inc;
					res.nack_update = 1'b1;
					res.nack_level  = ({1'b0, ptr_inc} == lim);
				end else begin
					// past the limit: byte dropped
					idx_n = idx_q + 8'd1;
				end
			end
			itrf_pkg::CMD_HRD: begin
				res.host_read_data = rd_byte;
			end
			itrf_pkg::CMD_HWR: begin
				ram_we = fire && inr_s1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= S_IDLE;
			ptr_q <= 8'd0;
			idx_q <= 8'd0;
		end else begin
			case (st_q)
				S_IDLE: begin
					if (acc) begin
						st_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (fire) begin
						st_q  <= S_IDLE;
						ptr_q <= ptr_n;
						idx_q <= idx_n;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (ram_we) begin
			vld_q[addr_s1[AW-1:0]] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			cmd_s1  <= req.cmd;
			data_s1 <= req.data_byte;
			addr_s1 <= rd_addr;
			inr_s1  <= rd_inr;
			vld_s1  <= rd_inr ? vld_q[rd_addr[AW-1:0]] : 1'b0;
		end
	end

	a_acc_to_exec: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> (st_q == S_EXEC))
		else $error("accepted transaction did not enter execute");

	a_we_in_exec: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (fire && inr_s1))
		else $error("ram write outside a completing in-range transaction");

	a_addr_clears_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && cmd_s1 == itrf_pkg::CMD_ADDR) |=> (idx_q == 8'd0))
		else $error("address event did not clear byte index");

	a_ptr_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(fire) |-> $stable(ptr_q))
		else $error("pointer changed without a completing transaction");
endmodule

// ===== hdl/i2c_target_register_file_top.sv =====
// i2c target register file: size register, core sequencer and output register
// Usage: the i2c bus logic and the local host send one transaction per event on
// req (cmd, data_byte, host_addr). Each request gives exactly one response on rsp:
// a byte to transmit (tx_valid/tx_byte), a nack change (nack_update/nack_level)
// and host read data. cfg_we/cfg_wdata load mem_size (bytes in use, reset 255);
// write it only while no transaction is in flight.
// A request accepted on req is registered into the core stage registers and the ram
// read data, then loaded into the output register when rsp is free, which raises
// rsp.valid. req.ready is low in the execute state, where the registered ram read
// is modified and written back, so the core holds one request at a time.
// A stalled rsp holds its transaction and the core waits in its execute cycle
// with req.ready low; a new request is taken while a finished response waits.
// Reset: pointer and byte index clear, mem_size returns to 255 and all entry valid
// bits clear at once, so every register byte reads 0 until written.
module i2c_target_register_file_top #(
	parameter int unsigned MEM_DEPTH = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	itrf_req_if.sink   req,
	itrf_rsp_if.source rsp,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata
);
	logic [7:0]     mem_size_q;
	logic           ovalid_q;
	itrf_pkg::res_t ores_q;
	logic           res_valid;
	logic           res_ready;
	itrf_pkg::res_t res;

	assign res_ready = !ovalid_q || rsp.ready;

	itrf_core #(
		.MEM_DEPTH (MEM_DEPTH)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.mem_size  (mem_size_q),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mem_size_q <= 8'd255;
			ovalid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				mem_size_q <= cfg_wdata;
			end
			if (res_ready) begin
				ovalid_q <= res_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			ores_q <= res;
		end
	end

	assign rsp.valid          = ovalid_q;
	assign rsp.tx_valid       = ores_q.tx_valid;
	assign rsp.tx_byte        = ores_q.tx_byte;
	assign rsp.nack_update    = ores_q.nack_update;
	assign rsp.nack_level     = ores_q.nack_level;
	assign rsp.host_read_data = ores_q.host_read_data;
endmodule
